>>> src/spiq_pkg.sv
// spiq_pkg: shared types and constants for the stable priority insert queue.
// No dependencies; used by stable_priority_insert_queue.
package spiq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TAG_W   = 16;
    localparam int ARR_W   = 16;
    localparam int COND_W  = 4;
    localparam int LEVEL_W = 3;
    localparam int POS_W   = 4;

    localparam int IN_DATA_W  = 40;   // 39 bits of fields, padded to bytes
    localparam int OUT_DATA_W = 48;   // 43 bits of fields, padded to bytes

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_VIEW   = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_LISTED   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [ARR_W-1:0]   arrival;
        logic [COND_W-1:0]  cond;
        logic [LEVEL_W-1:0] level;
    } t_entry;

endpackage

>>> src/stable_priority_insert_queue.sv
// stable_priority_insert_queue: sorted entry table with stable insert and ordered view.
// Depends on spiq_pkg (types, widths, status and action codes).
//
// Keeps up to QUEUE_DEPTH (16) entries sorted by priority level, lowest most urgent;
// a new entry lands behind every entry of equal or lower level, so equal levels
// keep arrival order. An insert request (tuser = 0) answers with one result,
// status inserted or rejected when the table is full. A view request (tuser = 1)
// lists every entry head to tail with tlast on the final one, or a single empty
// status. The table lives in a single-port-read, single-port-write memory and
// one level comparator walks it under a small sequencer, so the block takes one
// request at a time; tready stays low until it is idle again. An insert reads
// and compares each entry above the free slot in turn, shifting it down, until
// it writes the new entry; a view does one registered memory read per entry; a
// rejected insert or an empty view goes straight to its answer; an output stall
// holds any of these. Only entries below the fill count are ever read, so the
// memory needs no clearing after reset. The result sits in an output register,
// so a new request is taken while the previous result still waits downstream.
module stable_priority_insert_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata, low bit up: entry_tag[16], arrival_number[16], condition_code[4],
    //                    priority_level[3], zero pad[1]
    input  logic [spiq_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // tuser: action[1]
    input  logic        i_s_axis_tuser,
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata, low bit up: out_tag[16], out_arrival[16], out_condition[4],
    //                    out_level[3], position[4], zero pad[5]
    output logic [spiq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: status[2]
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,    // place new entry at r_idx or fetch the entry above it
        S_INS_CMP,    // compare fetched level, shift down or place
        S_RESP,       // single-result answer
        S_VIEW_RD,    // fetch entry r_idx
        S_VIEW_OUT    // present fetched entry
    } t_state;

    // table memory
    spiq_pkg::t_entry mem [spiq_pkg::QUEUE_DEPTH];
    spiq_pkg::t_entry r_rd;

    logic                       mem_we;
    logic [spiq_pkg::IDX_W-1:0] mem_waddr;
    spiq_pkg::t_entry           mem_wdata;
    logic                       mem_re;
    logic [spiq_pkg::IDX_W-1:0] mem_raddr;

    // control and payload registers
    t_state                     r_state, n_state;
    logic [spiq_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [spiq_pkg::IDX_W-1:0] r_idx, n_idx;
    spiq_pkg::t_entry           r_new, n_new;
    spiq_pkg::t_status          r_resp_status, n_resp_status;  // pending single answer

    logic                       r_out_valid, n_out_valid;
    spiq_pkg::t_status          r_out_status, n_out_status;
    spiq_pkg::t_entry           r_out_entry, n_out_entry;
    logic [spiq_pkg::POS_W-1:0] r_out_pos, n_out_pos;
    logic                       r_out_last, n_out_last;

    logic                       out_free;
    logic                       in_fire;
    spiq_pkg::t_entry           in_entry;
    logic                       view_last;
    logic                       shift_down;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;

    // struct order: tag, arrival, cond, level (tag in the top bits)
    assign in_entry = {i_s_axis_tdata[15:0], i_s_axis_tdata[31:16],
                       i_s_axis_tdata[35:32], i_s_axis_tdata[38:36]};

    // the shared comparator: stored entry sorts behind the new one
    assign shift_down = (r_rd.level > r_new.level);
    assign view_last  = (spiq_pkg::CNT_W'(r_idx) + spiq_pkg::CNT_W'(1) == r_cnt);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_idx         = r_idx;
        n_new         = r_new;
        n_resp_status = r_resp_status;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_status  = r_out_status;
        n_out_entry   = r_out_entry;
        n_out_pos     = r_out_pos;
        n_out_last    = r_out_last;
        mem_we        = 1'b0;
        mem_waddr     = r_idx;
        mem_wdata     = r_new;
        mem_re        = 1'b0;
        mem_raddr     = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_new = in_entry;
                    n_idx = spiq_pkg::IDX_W'(r_cnt);
                    if (i_s_axis_tuser == spiq_pkg::ACT_INSERT) begin
                        if (r_cnt == spiq_pkg::CNT_W'(spiq_pkg::QUEUE_DEPTH)) begin
                            n_resp_status = spiq_pkg::ST_REJECTED;
                            n_state       = S_RESP;
                        end else begin
                            n_resp_status = spiq_pkg::ST_INSERTED;
                            n_state       = S_INS_CHK;
                        end
                    end else begin
                        n_idx = '0;
                        if (r_cnt == '0) begin
                            n_resp_status = spiq_pkg::ST_EMPTY;
                            n_state       = S_RESP;
                        end else begin
                            n_state = S_VIEW_RD;
                        end
                    end
                end
            end
            S_INS_CHK: begin
                if (r_idx == '0) begin
                    mem_we  = 1'b1;
                    n_cnt   = r_cnt + spiq_pkg::CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx - spiq_pkg::IDX_W'(1);
                    n_state   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                mem_we = 1'b1;
                if (shift_down) begin
                    mem_wdata = r_rd;
                    n_idx     = r_idx - spiq_pkg::IDX_W'(1);
                    n_state   = S_INS_CHK;
                end else begin
                    n_cnt   = r_cnt + spiq_pkg::CNT_W'(1);
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_resp_status;
                    n_out_entry  = '0;
                    n_out_pos    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_VIEW_RD: begin
                mem_re  = 1'b1;
                n_state = S_VIEW_OUT;
            end
            S_VIEW_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = spiq_pkg::ST_LISTED;
                    n_out_entry  = r_rd;
                    n_out_pos    = spiq_pkg::POS_W'(r_idx);
                    n_out_last   = view_last;
                    if (view_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + spiq_pkg::IDX_W'(1);
                        n_state = S_VIEW_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_idx         <= n_idx;
        r_new         <= n_new;
        r_resp_status <= n_resp_status;
        r_out_status  <= n_out_status;
        r_out_entry   <= n_out_entry;
        r_out_pos     <= n_out_pos;
        r_out_last    <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= mem[mem_raddr];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {5'b0, r_out_pos, r_out_entry.level, r_out_entry.cond,
                              r_out_entry.arrival, r_out_entry.tag};

    // fill count stays within the table
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= spiq_pkg::CNT_W'(spiq_pkg::QUEUE_DEPTH))
        else $error("entry count beyond table depth");

    // the count only ever grows by one, once per accepted insert
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_cnt != $past(r_cnt)) |->
            (r_cnt == $past(r_cnt) + spiq_pkg::CNT_W'(1)))
        else $error("entry count changed by other than one");

    // the final listed entry of a view is the tail of the table; checked while
    // idle, since a later insert may grow the table while the entry still waits
    a_view_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_out_valid && r_out_status == spiq_pkg::ST_LISTED
            && r_out_last) |->
            (r_out_pos == spiq_pkg::POS_W'(r_cnt - spiq_pkg::CNT_W'(1))))
        else $error("view ended away from the table tail");

    // a view never reads past the filled part of the table
    a_view_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VIEW_RD) |-> (spiq_pkg::CNT_W'(r_idx) < r_cnt))
        else $error("view read beyond fill count");

endmodule

>>> tb/spiq_checker.sv
// spiq_checker: watches both stream channels of the priority insert queue, keeps its own
// sorted copy of the table and compares every result with the predicted one.
// Depends on spiq_pkg for widths, entry layout and the action and status codes.
`timescale 1ns / 1ps

module spiq_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [spiq_pkg::IN_DATA_W-1:0]  i_req_data,
    input  logic                            i_req_user,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [spiq_pkg::OUT_DATA_W-1:0] i_rsp_data,
    input  logic [1:0]                      i_rsp_user,
    input  logic                            i_rsp_last,
    output int                              o_fail_count,
    output int                              o_pending
);

    // field offsets inside tdata, lowest field first
    localparam int ARR_LO   = spiq_pkg::TAG_W;
    localparam int COND_LO  = ARR_LO + spiq_pkg::ARR_W;
    localparam int LEVEL_LO = COND_LO + spiq_pkg::COND_W;
    localparam int POS_LO   = LEVEL_LO + spiq_pkg::LEVEL_W;
    localparam int REPORT_MAX = 10;

    typedef struct {
        spiq_pkg::t_status          status;
        spiq_pkg::t_entry           ent;
        logic [spiq_pkg::POS_W-1:0] pos;
        logic                       last;
    } t_answer;

    spiq_pkg::t_entry sorted_tbl [spiq_pkg::QUEUE_DEPTH];
    int unsigned      fill;
    t_answer          answers_due [$];
    int               fails;

    // Update the shadow table for one request and queue the answers it causes.
    task automatic apply_request(input spiq_pkg::t_action act, input spiq_pkg::t_entry ent);
        t_answer     a;
        int unsigned at;
        int unsigned i;
        a.status = spiq_pkg::ST_INSERTED;
        a.ent    = '0;
        a.pos    = '0;
        a.last   = 1'b1;
        if (act == spiq_pkg::ACT_INSERT) begin
            if (fill >= spiq_pkg::QUEUE_DEPTH) begin
                a.status = spiq_pkg::ST_REJECTED;
            end else begin
                // new entry goes behind every entry of equal or more urgent level
                at = fill;
                for (i = 0; i < fill; i++)
                    if (sorted_tbl[i].level > ent.level && at == fill)
                        at = i;
                for (i = fill; i > at; i--)
                    sorted_tbl[i] = sorted_tbl[i-1];
                sorted_tbl[at] = ent;
                fill++;
            end
            answers_due.push_back(a);
        end else if (fill == 0) begin
            a.status = spiq_pkg::ST_EMPTY;
            answers_due.push_back(a);
        end else begin
            for (i = 0; i < fill; i++) begin
                a.status = spiq_pkg::ST_LISTED;
                a.ent    = sorted_tbl[i];
                a.pos    = spiq_pkg::POS_W'(i);
                a.last   = (i + 1 == fill);
                answers_due.push_back(a);
            end
        end
    endtask

    task automatic check_answer(input spiq_pkg::t_status st, input spiq_pkg::t_entry ent,
                                input logic [spiq_pkg::POS_W-1:0] pos, input logic lst);
        t_answer want;
        if (answers_due.size() == 0) begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("%0t: result with nothing expected: status %0d tag %h pos %0d",
                         $realtime, st, ent.tag, pos);
        end else begin
            want = answers_due.pop_front();
            if (st !== want.status || ent.tag !== want.ent.tag
                    || ent.arrival !== want.ent.arrival || ent.cond !== want.ent.cond
                    || ent.level !== want.ent.level || pos !== want.pos
                    || lst !== want.last) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("%0t: result mismatch (exp/got): status %0d/%0d tag %h/%h ",
                             $realtime, want.status, st, want.ent.tag, ent.tag,
                             "arrival %h/%h cond %h/%h level %0d/%0d pos %0d/%0d last %b/%b",
                             want.ent.arrival, ent.arrival, want.ent.cond, ent.cond,
                             want.ent.level, ent.level, want.pos, pos, want.last, lst);
            end
        end
    endtask

    initial begin
        fill         = 0;
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : watch
        spiq_pkg::t_entry req_ent;
        spiq_pkg::t_entry rsp_ent;
        if (!i_rst_n) begin
            fill = 0;
            answers_due.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                req_ent.tag     = i_req_data[0 +: spiq_pkg::TAG_W];
                req_ent.arrival = i_req_data[ARR_LO +: spiq_pkg::ARR_W];
                req_ent.cond    = i_req_data[COND_LO +: spiq_pkg::COND_W];
                req_ent.level   = i_req_data[LEVEL_LO +: spiq_pkg::LEVEL_W];
                apply_request(spiq_pkg::t_action'(i_req_user), req_ent);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                rsp_ent.tag     = i_rsp_data[0 +: spiq_pkg::TAG_W];
                rsp_ent.arrival = i_rsp_data[ARR_LO +: spiq_pkg::ARR_W];
                rsp_ent.cond    = i_rsp_data[COND_LO +: spiq_pkg::COND_W];
                rsp_ent.level   = i_rsp_data[LEVEL_LO +: spiq_pkg::LEVEL_W];
                check_answer(spiq_pkg::t_status'(i_rsp_user), rsp_ent,
                             i_rsp_data[POS_LO +: spiq_pkg::POS_W], i_rsp_last);
            end
        end
        o_fail_count <= fails;
        o_pending    <= answers_due.size();
    end

endmodule

>>> tb/tb.sv
// tb: stimulus and verdict for stable_priority_insert_queue; the checking lives in
// spiq_checker, which sits beside the block and reports failures and open answers.
// Depends on spiq_pkg, spiq_checker and stable_priority_insert_queue.
`timescale 1ns / 1ps

module tb;

    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int IDLE_LIMIT   = 3000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 40;    // longest busy stretch is an insert shifting 15 entries
    localparam int PHASE_ITEMS  = 34;    // random requests per idling phase
    localparam int INSERT_PCT   = 40;

    logic                            clk;
    logic                            rst_n;
    logic                            req_valid;
    logic                            req_ready;
    logic [spiq_pkg::IN_DATA_W-1:0]  req_data;
    logic                            req_user;
    logic                            rsp_valid;
    logic                            rsp_ready = 1'b0;
    logic [spiq_pkg::OUT_DATA_W-1:0] rsp_data;
    logic [1:0]                      rsp_user;
    logic                            rsp_last;

    int   fail_count;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_go     = 1'b0;
    logic hold_taken  = 1'b0;
    int   hold_left   = 0;
    int   quiet_cycles = 0;

    stable_priority_insert_queue dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_user),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data),
        .o_m_axis_tuser  (rsp_user),
        .o_m_axis_tlast  (rsp_last)
    );

    spiq_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_data   (req_data),
        .i_req_user   (req_user),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp_data   (rsp_data),
        .i_rsp_user   (rsp_user),
        .i_rsp_last   (rsp_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random backpressure, plus one long hold-off on request so the
    // block fills its output register and stalls the request side.
    always @(posedge clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Cycles since the last handshake on either channel.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("stable_priority_insert_queue verification failed");
        $finish;
    end

    function automatic spiq_pkg::t_entry make_entry(
            input logic [spiq_pkg::TAG_W-1:0]   tag,
            input logic [spiq_pkg::ARR_W-1:0]   arrival,
            input logic [spiq_pkg::COND_W-1:0]  cond,
            input logic [spiq_pkg::LEVEL_W-1:0] level);
        spiq_pkg::t_entry e;
        e.tag     = tag;
        e.arrival = arrival;
        e.cond    = cond;
        e.level   = level;
        return e;
    endfunction

    // Mostly legal levels 1..4; now and then anything the 3-bit field holds.
    function automatic spiq_pkg::t_entry random_entry();
        logic [spiq_pkg::LEVEL_W-1:0] lvl;
        lvl = ($urandom_range(4) == 0) ? spiq_pkg::LEVEL_W'($urandom_range(7))
                                       : spiq_pkg::LEVEL_W'($urandom_range(4, 1));
        return make_entry(spiq_pkg::TAG_W'($urandom), spiq_pkg::ARR_W'($urandom),
                          spiq_pkg::COND_W'($urandom_range(15)), lvl);
    endfunction

    // Offer one request and hold it until taken. Valid only drops inside an idle gap,
    // so it never gets two assignments in one step.
    task automatic send_request(input spiq_pkg::t_action act, input spiq_pkg::t_entry ent);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_user  <= act;
        req_data  <= {1'b0, ent.level, ent.cond, ent.arrival, ent.tag};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Stop offering until every predicted answer has come back.
    task automatic wait_answers();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial begin
        spiq_pkg::t_entry  seeds [10];
        spiq_pkg::t_action act;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_user  = 1'b0;
        req_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every level value 0..7, equal levels kept in
        // arrival order, views of an empty and of a partly filled table.
        seeds[0] = make_entry(16'hFFFF, 16'h0000, 4'hF, 3'd4);
        seeds[1] = make_entry(16'h0000, 16'hFFFF, 4'h0, 3'd1);
        seeds[2] = make_entry(16'h1234, 16'h0001, 4'h5, 3'd4);
        seeds[3] = make_entry(16'hAAAA, 16'h5555, 4'hA, 3'd0);
        seeds[4] = make_entry(16'h5555, 16'hAAAA, 4'h5, 3'd7);
        seeds[5] = make_entry(16'h0001, 16'h8000, 4'h8, 3'd2);
        seeds[6] = make_entry(16'h8000, 16'h0002, 4'h7, 3'd5);
        seeds[7] = make_entry(16'h0F0F, 16'hF0F0, 4'h3, 3'd6);
        seeds[8] = make_entry(16'hF0F0, 16'h0F0F, 4'hC, 3'd3);
        seeds[9] = make_entry(16'h7FFF, 16'h8001, 4'h1, 3'd1);

        send_request(spiq_pkg::ACT_VIEW, make_entry('0, '0, '0, '0));
        for (int k = 0; k < 10; k++) begin
            send_request(spiq_pkg::ACT_INSERT, seeds[k]);
            if (k == 4)
                send_request(spiq_pkg::ACT_VIEW, make_entry('1, '1, '1, '1));
        end
        send_request(spiq_pkg::ACT_VIEW, random_entry());
        wait_answers();

        // Random: the table fills up during the first phase, after which inserts
        // come back rejected and every view lists all sixteen entries.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 15;
                    rx_idle_pct = 54;
                    hold_go <= 1'b1;
                end
                1: begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 15;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                act = ($urandom_range(99) < INSERT_PCT) ? spiq_pkg::ACT_INSERT
                                                        : spiq_pkg::ACT_VIEW;
                send_request(act, random_entry());
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    wait_answers();
            end
        end

        wait_answers();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("stable_priority_insert_queue verification clean");
        else
            $display("stable_priority_insert_queue verification failed");
        $finish;
    end

endmodule

>>> files.f
src/spiq_pkg.sv
src/stable_priority_insert_queue.sv
tb/spiq_checker.sv
tb/tb.sv
